[hw/rtl/smm_pkg.sv]
// ----------------------------------------------------------------------------
// smm_pkg: shared types and codes of the slotted message mailbox
// Request, response and configuration structs, status codes, register
// indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

   // Request kinds
   localparam logic REQ_SEND = 1'b0;
   localparam logic REQ_RECV = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_SLOT_COUNT     = 2'd0;
   localparam logic [1:0] CSR_SLOT_BYTES     = 2'd1;
   localparam logic [1:0] CSR_OVERWRITE_MODE = 2'd2;
   localparam logic [1:0] CSR_MAX_READ_LEN   = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_TOO_LONG  = 3'd2,
      ST_FULL      = 3'd3,
      ST_BAD_INDEX = 3'd4,
      ST_BAD_LEN   = 3'd5
   } smm_status_type;

   typedef struct packed {
      logic        req_type;
      logic [1:0]  queue_sel;
      logic [15:0] send_len;
      logic [31:0] data_word;
      logic        last_word;
   } smm_req_type;

   typedef struct packed {
      smm_status_type status;
      logic [31:0]    read_word;
      logic [8:0]     stored_len;
      logic           end_of_run;
      logic           overwrote;
      logic [15:0]    overrun_count;
   } smm_rsp_type;

   typedef struct packed {
      logic [4:0] slot_count;
      logic [8:0] slot_bytes;
      logic       overwrite_mode;
      logic [8:0] max_read_len;
   } smm_cfg_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CTRL,
      S_LEN,
      S_DATA
   } smm_state_type;

endpackage

`default_nettype wire

[hw/rtl/smm_ram.sv]
// ----------------------------------------------------------------------------
// smm_ram: generic single-write, single-read synchronous RAM
// One write port, one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic                                       re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hw/rtl/smm_engine.sv]
// ----------------------------------------------------------------------------
// smm_engine: mailbox sequencer and its memories
// Reads per-queue control, checks and commits sends, streams received
// slots out of the payload memory one word per cycle while the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_engine #(
   parameter int NUM_QUEUES = 4,
   parameter int NUM_SLOTS  = 16,
   parameter int SLOT_WORDS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire smm_pkg::smm_cfg_type cfg,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire smm_pkg::smm_req_type req_data,
   input  wire logic                 out_free,
   output logic                      rsp_load,
   output smm_pkg::smm_rsp_type      rsp_data
);

   localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int SIW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int WIW    = $clog2(NUM_SLOTS + 1);
   localparam int KW     = $clog2(SLOT_WORDS + 1);
   localparam int KIW    = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
   localparam int PDEPTH = NUM_QUEUES * NUM_SLOTS * SLOT_WORDS;
   localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
   localparam int LDEPTH = NUM_QUEUES * NUM_SLOTS;
   localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
   localparam int CW     = WIW + SIW + 16;

   // Fold the queue number into range (few subtract steps on two bits)
   function automatic logic [QW-1:0] map_queue(input logic [1:0] id);
      int v;
      v = int'(id);
      for (int i = 0; i < 4; i++) begin
         if (v >= NUM_QUEUES) v = v - NUM_QUEUES;
      end
      return QW'(v);
   endfunction

   function automatic logic [PAW-1:0] pay_addr(input logic [QW-1:0]  q,
                                                input logic [SIW-1:0] slot,
                                                input logic [KIW-1:0] k);
      return (PAW'(q) * PAW'(NUM_SLOTS) + PAW'(slot)) * PAW'(SLOT_WORDS) + PAW'(k);
   endfunction

   function automatic logic [LAW-1:0] len_addr(input logic [QW-1:0]  q,
                                               input logic [SIW-1:0] slot);
      return LAW'(q) * LAW'(NUM_SLOTS) + LAW'(slot);
   endfunction

   // Registers
   smm_pkg::smm_state_type state_ff, state_in;
   smm_pkg::smm_req_type   req_ff, req_in;
   logic [QW-1:0]          q_ff, q_in;
   logic [KW-1:0]          word_cnt_ff, word_cnt_in;
   logic [WIW-1:0]         w_ff, w_in;
   logic [SIW-1:0]         r_ff, r_in;
   logic [15:0]            cnt_ff, cnt_in;
   logic [KW-1:0]          words_ff, words_in;
   logic [KW-1:0]          k_ff, k_in;
   logic                   ctrl_vld_ff [NUM_QUEUES];

   // Memory ports
   logic                   ctrl_we, ctrl_re;
   logic [QW-1:0]          ctrl_addr;
   logic [CW-1:0]          ctrl_wdata, ctrl_rdata;
   logic                   len_we, len_re;
   logic [LAW-1:0]         len_waddr, len_raddr;
   logic [8:0]             len_wdata, len_rdata;
   logic                   pay_we, pay_re;
   logic [PAW-1:0]         pay_waddr, pay_raddr;
   logic [31:0]            pay_rdata;

   // Datapath terms
   logic [WIW-1:0]         n_eff;
   logic [CW-1:0]          ctrl_word;
   logic [WIW-1:0]         cur_w;
   logic [SIW-1:0]         cur_r;
   logic [15:0]            cur_cnt;
   logic                   slot_ok, word_room;
   logic [WIW-1:0]         w_plus, w_wrap, w_new, r_plus, r_wrap;
   logic                   too_long, full, ovr;
   logic [15:0]            cnt_new;
   logic [9:0]             len_round;
   logic [7:0]             words_raw;
   logic [KW-1:0]          words_cap;
   logic [KW-1:0]          k_next;
   logic                   len_bad;

   assign n_eff = (int'(cfg.slot_count) > NUM_SLOTS) ? WIW'(NUM_SLOTS)
                                                     : WIW'(cfg.slot_count);

   assign ctrl_word = ctrl_vld_ff[q_ff] ? ctrl_rdata : '0;
   assign cur_w     = ctrl_word[CW-1 -: WIW];
   assign cur_r     = ctrl_word[16 +: SIW];
   assign cur_cnt   = ctrl_word[15:0];

   assign slot_ok   = cur_w < n_eff;
   assign word_room = word_cnt_ff < KW'(SLOT_WORDS);
   assign w_plus    = cur_w + WIW'(1);
   assign w_wrap    = (w_plus == n_eff) ? '0 : w_plus;
   assign too_long  = req_ff.send_len > 16'(cfg.slot_bytes);
   assign full      = !cfg.overwrite_mode && (w_wrap == WIW'(cur_r));
   assign w_new     = (n_eff == WIW'(1)) ? WIW'(1) : w_wrap;
   assign ovr       = w_new == WIW'(cur_r);
   assign cnt_new   = cur_cnt + 16'(ovr);

   assign r_plus    = WIW'(r_ff) + WIW'(1);
   assign r_wrap    = (r_plus == n_eff) ? '0 : r_plus;
   assign len_bad   = (len_rdata == 9'd0) || (len_rdata > cfg.max_read_len);
   assign len_round = {1'b0, len_rdata} + 10'd3;
   assign words_raw = len_round[9:2];
   assign words_cap = (int'(words_raw) > SLOT_WORDS) ? KW'(SLOT_WORDS) : KW'(words_raw);
   assign k_next    = k_ff + KW'(1);

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      q_in        = q_ff;
      word_cnt_in = word_cnt_ff;
      w_in        = w_ff;
      r_in        = r_ff;
      cnt_in      = cnt_ff;
      words_in    = words_ff;
      k_in        = k_ff;
      req_ready   = 1'b0;
      ctrl_re     = 1'b0;
      ctrl_we     = 1'b0;
      ctrl_addr   = q_ff;
      ctrl_wdata  = {w_new, cur_r, cnt_new};
      len_we      = 1'b0;
      len_re      = 1'b0;
      len_waddr   = len_addr(q_ff, cur_w[SIW-1:0]);
      len_raddr   = len_addr(q_ff, cur_r);
      len_wdata   = req_ff.send_len[8:0];
      pay_we      = 1'b0;
      pay_re      = 1'b0;
      pay_waddr   = pay_addr(q_ff, cur_w[SIW-1:0], word_cnt_ff[KIW-1:0]);
      pay_raddr   = pay_addr(q_ff, r_ff, k_ff[KIW-1:0]);
      rsp_load    = 1'b0;
      rsp_data    = '0;
      rsp_data.end_of_run    = 1'b1;
      rsp_data.overrun_count = cur_cnt;

      unique case (state_ff)
         smm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in    = req_data;
               q_in      = map_queue(req_data.queue_sel);
               ctrl_re   = 1'b1;
               ctrl_addr = map_queue(req_data.queue_sel);
               state_in  = smm_pkg::S_CTRL;
            end
         end

         smm_pkg::S_CTRL: begin
            w_in   = cur_w;
            r_in   = cur_r;
            cnt_in = cur_cnt;
            if (req_ff.req_type == smm_pkg::REQ_SEND) begin
               // hold a commit until the output register can take its result
               if (!req_ff.last_word || out_free) begin
                  pay_we   = slot_ok && word_room;
                  state_in = smm_pkg::S_IDLE;
                  if (req_ff.last_word) begin
                     word_cnt_in = '0;
                     rsp_load    = 1'b1;
                     priority if (too_long) begin
                        rsp_data.status = smm_pkg::ST_TOO_LONG;
                     end else if (!slot_ok) begin
                        rsp_data.status = smm_pkg::ST_BAD_INDEX;
                     end else if (full) begin
                        rsp_data.status = smm_pkg::ST_FULL;
                     end else begin
                        len_we  = 1'b1;
                        ctrl_we = 1'b1;
                        rsp_data.status        = smm_pkg::ST_OK;
                        rsp_data.overwrote     = ovr;
                        rsp_data.overrun_count = cnt_new;
                     end
                  end else if (word_room) begin
                     word_cnt_in = word_cnt_ff + KW'(1);
                  end
               end
            end else begin
               priority if (WIW'(cur_r) == cur_w) begin
                  if (out_free) begin
                     rsp_load        = 1'b1;
                     rsp_data.status = smm_pkg::ST_EMPTY;
                     state_in        = smm_pkg::S_IDLE;
                  end
               end else if (WIW'(cur_r) >= n_eff) begin
                  if (out_free) begin
                     rsp_load        = 1'b1;
                     rsp_data.status = smm_pkg::ST_BAD_INDEX;
                     state_in        = smm_pkg::S_IDLE;
                  end
               end else begin
                  len_re   = 1'b1;
                  state_in = smm_pkg::S_LEN;
               end
            end
         end

         smm_pkg::S_LEN: begin
            rsp_data.overrun_count = cnt_ff;
            if (len_bad) begin
               if (out_free) begin
                  rsp_load        = 1'b1;
                  rsp_data.status = smm_pkg::ST_BAD_LEN;
                  state_in        = smm_pkg::S_IDLE;
               end
            end else begin
               // advance the read index and fetch the first word
               ctrl_we    = 1'b1;
               ctrl_wdata = {((n_eff == WIW'(1)) ? WIW'(0) : w_ff), r_wrap[SIW-1:0], cnt_ff};
               words_in   = words_cap;
               k_in       = '0;
               pay_re     = 1'b1;
               pay_raddr  = pay_addr(q_ff, r_ff, '0);
               state_in   = smm_pkg::S_DATA;
            end
         end

         smm_pkg::S_DATA: begin
            rsp_data.overrun_count = cnt_ff;
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_data.status     = smm_pkg::ST_OK;
               rsp_data.read_word  = pay_rdata;
               rsp_data.stored_len = len_rdata;
               rsp_data.end_of_run = k_next == words_ff;
               if (k_next == words_ff) begin
                  state_in = smm_pkg::S_IDLE;
               end else begin
                  pay_re    = 1'b1;
                  pay_raddr = pay_addr(q_ff, r_ff, k_next[KIW-1:0]);
                  k_in      = k_next;
               end
            end
         end

         default: begin
            state_in = smm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= smm_pkg::S_IDLE;
         word_cnt_ff <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            ctrl_vld_ff[i] <= 1'b0;
         end
      end else begin
         state_ff    <= state_in;
         word_cnt_ff <= word_cnt_in;
         if (ctrl_we) begin
            ctrl_vld_ff[ctrl_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      q_ff     <= q_in;
      w_ff     <= w_in;
      r_ff     <= r_in;
      cnt_ff   <= cnt_in;
      words_ff <= words_in;
      k_ff     <= k_in;
   end

   smm_ram #(.WIDTH(CW), .DEPTH(NUM_QUEUES)) u_ctrl_ram (
      .clock (clock),
      .we    (ctrl_we),
      .waddr (ctrl_addr),
      .wdata (ctrl_wdata),
      .re    (ctrl_re),
      .raddr (ctrl_addr),
      .rdata (ctrl_rdata)
   );

   smm_ram #(.WIDTH(9), .DEPTH(LDEPTH)) u_len_ram (
      .clock (clock),
      .we    (len_we),
      .waddr (len_waddr),
      .wdata (len_wdata),
      .re    (len_re),
      .raddr (len_raddr),
      .rdata (len_rdata)
   );

   smm_ram #(.WIDTH(32), .DEPTH(PDEPTH)) u_pay_ram (
      .clock (clock),
      .we    (pay_we),
      .waddr (pay_waddr),
      .wdata (req_ff.data_word),
      .re    (pay_re),
      .raddr (pay_raddr),
      .rdata (pay_rdata)
   );

   a_pay_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(pay_we && pay_re))
      else $error("payload write and read in the same cycle");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded while output register is occupied");

   a_recv_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != smm_pkg::S_IDLE && req_ff.req_type == smm_pkg::REQ_RECV)
      |=> $stable(word_cnt_ff))
      else $error("receive changed the send word count");

   a_ctrl_write_phase: assert property (@(posedge clock) disable iff (reset)
      ctrl_we |-> ((state_ff == smm_pkg::S_CTRL && req_ff.req_type == smm_pkg::REQ_SEND)
                   || state_ff == smm_pkg::S_LEN))
      else $error("control write outside a commit or receive update");

endmodule

`default_nettype wire

[hw/rtl/slotted_message_mailbox.sv]
// ----------------------------------------------------------------------------
// slotted_message_mailbox: multi-queue ring mailbox with fixed-size slots
// Configuration registers, result output register and the sequencer.
// ----------------------------------------------------------------------------
// Each queue is a ring of slots held in a payload memory, with a stored byte
// length per slot in a length memory and the write index, read index and
// overrun counter per queue in a small control memory (per-queue valid bits,
// cleared by reset, make unwritten control read as zero, so no clearing pass
// runs after reset). A send word goes through the control memory read, then
// the word write (and, on the last word, the check, commit and result
// load). A receive that finds its queue empty or its read index out of
// range reports after the control read; one that finds a bad stored length
// goes through control read, length read and result. A good receive goes
// through control read, length read and payload read to its first word and
// then delivers one word per cycle while rsp_ready stays high, holding the
// block until its last word is handed over. Results sit in an output
// register, so an item finishing while the previous result waits only
// stalls once it has a result of its own to hand over.
// ----------------------------------------------------------------------------
`default_nettype none

module slotted_message_mailbox #(
   parameter int NUM_QUEUES = 4,
   parameter int NUM_SLOTS  = 16,
   parameter int SLOT_WORDS = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire smm_pkg::smm_req_type                 req_data,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output smm_pkg::smm_rsp_type                      rsp_data,
   // configuration write port
   input  wire logic                                 csr_we,
   input  wire logic [smm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [smm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   smm_pkg::smm_cfg_type cfg_ff, cfg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   smm_pkg::smm_rsp_type rsp_data_ff, rsp_data_in;
   logic                 out_free;
   logic                 rsp_load;
   smm_pkg::smm_rsp_type eng_rsp;

   // Register writes: take the low bits of the data for each field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            smm_pkg::CSR_SLOT_COUNT:     cfg_in.slot_count     = csr_wdata[4:0];
            smm_pkg::CSR_SLOT_BYTES:     cfg_in.slot_bytes     = csr_wdata[8:0];
            smm_pkg::CSR_OVERWRITE_MODE: cfg_in.overwrite_mode = csr_wdata[0];
            smm_pkg::CSR_MAX_READ_LEN:   cfg_in.max_read_len   = csr_wdata[8:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_count     <= 5'd16;
         cfg_ff.slot_bytes     <= 9'd256;
         cfg_ff.overwrite_mode <= 1'b0;
         cfg_ff.max_read_len   <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Output register: free when empty or when its transfer completes now
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   smm_engine #(
      .NUM_QUEUES (NUM_QUEUES),
      .NUM_SLOTS  (NUM_SLOTS),
      .SLOT_WORDS (SLOT_WORDS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .rsp_data  (eng_rsp)
   );

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the slotted message mailbox
// Streams send words and receives into the request channel and keeps a
// shadow copy of the rings, lengths, indexes and overrun counters. From that
// copy it predicts every response and checks each one field by field. The
// run covers several register settings, the three back-pressure patterns
// and one long output stall that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb;

   localparam int NQ = 4;
   localparam int NS = 16;
   localparam int SW = 64;

   // Shadow copy of the mailbox: predicts responses and checks them in order.
   class mailbox_mirror;
      logic [31:0] words_mem [NQ*NS*SW];
      bit          word_set  [NQ*NS*SW];
      logic [8:0]  len_mem   [NQ*NS];
      bit          len_set   [NQ*NS];
      int unsigned wr_idx    [NQ];
      int unsigned rd_idx    [NQ];
      logic [15:0] overruns  [NQ];
      int unsigned word_pos;
      logic [4:0]  slots_reg;
      logic [8:0]  send_limit;
      logic        overwrite_on;
      logic [8:0]  recv_limit;
      smm_pkg::smm_rsp_type awaited_results [$];
      int unsigned mismatches;

      function new();
         foreach (wr_idx[i]) begin
            wr_idx[i]   = 0;
            rd_idx[i]   = 0;
            overruns[i] = '0;
         end
         word_pos     = 0;
         slots_reg    = 5'd16;
         send_limit   = 9'd256;
         overwrite_on = 1'b0;
         recv_limit   = 9'd256;
         mismatches   = 0;
      endfunction

      function int unsigned ring_slots();
         return (slots_reg > NS) ? NS : slots_reg;
      endfunction

      function void set_register(logic [1:0] idx, logic [8:0] val);
         case (idx)
            smm_pkg::CSR_SLOT_COUNT:     slots_reg    = val[4:0];
            smm_pkg::CSR_SLOT_BYTES:     send_limit   = val;
            smm_pkg::CSR_OVERWRITE_MODE: overwrite_on = val[0];
            smm_pkg::CSR_MAX_READ_LEN:   recv_limit   = val;
            default: ;
         endcase
      endfunction

      // A receive must never touch a length or word that was never written.
      function bit recv_is_safe(int unsigned q);
         int unsigned n, r, slot, stored, words;
         n = ring_slots();
         r = rd_idx[q];
         if (r == wr_idx[q] || r >= n)
            return 1'b1;
         slot = q * NS + r;
         if (!len_set[slot])
            return 1'b0;
         stored = len_mem[slot];
         if (stored == 0 || stored > recv_limit)
            return 1'b1;
         words = (stored + 3) / 4;
         if (words > SW)
            words = SW;
         for (int k = 0; k < words; k++) begin
            if (!word_set[slot * SW + k])
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void accept_request(smm_pkg::smm_req_type rq);
         int unsigned q, n, w, r, slot, stored, words;
         smm_pkg::smm_rsp_type res;
         q = rq.queue_sel % NQ;
         n = ring_slots();
         w = wr_idx[q];
         r = rd_idx[q];
         res = '0;
         res.status = smm_pkg::ST_OK;
         res.end_of_run = 1'b1;
         if (rq.req_type == smm_pkg::REQ_SEND) begin
            slot = q * NS + w;
            // the word counter is shared by all queues and saturates
            if (w < n && word_pos < SW) begin
               words_mem[slot * SW + word_pos] = rq.data_word;
               word_set[slot * SW + word_pos]  = 1'b1;
            end
            if (word_pos < SW)
               word_pos++;
            if (!rq.last_word)
               return;
            word_pos = 0;
            if (rq.send_len > send_limit)
               res.status = smm_pkg::ST_TOO_LONG;
            else if (w >= n)
               res.status = smm_pkg::ST_BAD_INDEX;
            else if (!overwrite_on && ((w + 1) % n) == r)
               res.status = smm_pkg::ST_FULL;
            else begin
               len_mem[slot] = rq.send_len[8:0];
               len_set[slot] = 1'b1;
               // a one-slot ring parks the write index at 1 until read
               w = (n == 1) ? 1 : (w + 1) % n;
               wr_idx[q] = w;
               if (w == r) begin
                  overruns[q]++;
                  res.overwrote = 1'b1;
               end
            end
         end else if (r == w) begin
            res.status = smm_pkg::ST_EMPTY;
         end else if (r >= n) begin
            res.status = smm_pkg::ST_BAD_INDEX;
         end else begin
            slot   = q * NS + r;
            stored = len_mem[slot];
            if (stored == 0 || stored > recv_limit)
               res.status = smm_pkg::ST_BAD_LEN;
            else begin
               words = (stored + 3) / 4;
               if (words > SW)
                  words = SW;
               rd_idx[q] = (r + 1) % n;
               if (n == 1)
                  wr_idx[q] = 0;
               for (int k = 0; k < words; k++) begin
                  res.read_word     = words_mem[slot * SW + k];
                  res.stored_len    = 9'(stored);
                  res.end_of_run    = (k + 1 == words);
                  res.overrun_count = overruns[q];
                  awaited_results.push_back(res);
               end
               return;
            end
         end
         res.overrun_count = overruns[q];
         awaited_results.push_back(res);
      endfunction

      function void compare_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_result(smm_pkg::smm_rsp_type got);
         smm_pkg::smm_rsp_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %h", $time, got);
            mismatches++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("read_word", want.read_word, got.read_word);
         compare_field("stored_len", want.stored_len, got.stored_len);
         compare_field("end_of_run", want.end_of_run, got.end_of_run);
         compare_field("overwrote", want.overwrote, got.overwrote);
         compare_field("overrun_count", want.overrun_count, got.overrun_count);
      endfunction
   endclass

   logic                                clock;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   smm_pkg::smm_req_type                req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   smm_pkg::smm_rsp_type                rsp_data;
   logic                                csr_we    = 1'b0;
   logic [smm_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [smm_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   mailbox_mirror mirror = new();

   // idle odds in percent per cycle for each side
   int unsigned tx_idle_pct = 22;
   int unsigned rx_idle_pct = 79;
   bit          hold_request = 1'b0;

   slotted_message_mailbox u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one request, idling first at random; hold it until the transfer.
   task automatic offer(input smm_pkg::smm_req_type item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      mirror.accept_request(item);
   endtask

   // Stream one message; send_len matters only on the last word.
   task automatic send_message(input int unsigned q, input int unsigned nwords,
                               input int unsigned len, input bit fixed,
                               input logic [31:0] fixed_word);
      smm_pkg::smm_req_type item;
      for (int unsigned i = 0; i < nwords; i++) begin
         item.req_type  = smm_pkg::REQ_SEND;
         item.queue_sel = 2'(q);
         item.last_word = (i == nwords - 1);
         item.send_len  = item.last_word ? 16'(len) : 16'($urandom);
         item.data_word = fixed ? fixed_word : $urandom;
         offer(item);
      end
   endtask

   // Ask for one message; the other fields are don't-care, so randomize them.
   task automatic receive(input int unsigned q);
      smm_pkg::smm_req_type item;
      item.req_type  = smm_pkg::REQ_RECV;
      item.queue_sel = 2'(q);
      item.send_len  = 16'($urandom);
      item.data_word = $urandom;
      item.last_word = 1'($urandom);
      offer(item);
   endtask

   // Drop valid and wait for every predicted response, then keep idling so a send
   // word with no response of its own has cleared the pipeline.
   task automatic settle();
      int unsigned spins;
      req_valid <= 1'b0;
      spins = 0;
      while (mirror.awaited_results.size() != 0 && spins < 50000) begin
         @(posedge clock);
         spins++;
      end
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [8:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.set_register(idx, val);
      @(posedge clock);
   endtask

   task automatic configure(input logic [8:0] slots, input logic [8:0] bytes,
                            input logic [8:0] ovw, input logic [8:0] rd_max);
      write_register(smm_pkg::CSR_SLOT_COUNT, slots);
      write_register(smm_pkg::CSR_SLOT_BYTES, bytes);
      write_register(smm_pkg::CSR_OVERWRITE_MODE, ovw);
      write_register(smm_pkg::CSR_MAX_READ_LEN, rd_max);
   endtask

   // Mostly well-formed messages with lengths that match their word count,
   // plus receives where safe, oversize lengths and zero lengths as noise.
   task automatic random_traffic(input int unsigned budget);
      int unsigned done, q, nwords, pick, len;
      done = 0;
      while (done < budget) begin
         q = $urandom_range(3);
         if ($urandom_range(99) < 45 && mirror.recv_is_safe(q)) begin
            receive(q);
            done++;
         end else begin
            pick = $urandom_range(99);
            if (pick < 3)
               nwords = SW;
            else if (pick < 12)
               nwords = $urandom_range(16, 5);
            else
               nwords = $urandom_range(4, 1);
            pick = $urandom_range(99);
            if (pick < 8)
               len = $urandom_range(65535);
            else if (pick < 12 && mirror.overwrite_on)
               len = 0;
            else
               len = $urandom_range((nwords == SW) ? 511 : 4 * nwords, 4 * nwords - 3);
            send_message(q, nwords, len, 1'b0, '0);
            done += nwords;
         end
      end
   endtask

   // Response side: check each transfer, then pick ready for the next cycle.
   // A hold request parks ready low for a long stretch counted here.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            mirror.check_result(rsp_data);
         if (hold_request) begin
            hold_left    = 400;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      smm_pkg::smm_req_type lone;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings: empty, single word with all ones,
      // oversize length, zero length then its bad stored length on receive.
      receive(0);
      send_message(0, 1, 4, 1'b1, 32'hFFFF_FFFF);
      send_message(1, 2, 16'hFFFF, 1'b1, 32'h0000_0000);
      receive(0);
      receive(1);
      send_message(3, 1, 0, 1'b0, '0);
      receive(3);
      // Interleave: a word for one queue bumps the shared word count, so the
      // last word of another queue lands one word in; make that commit fail.
      lone           = '0;
      lone.req_type  = smm_pkg::REQ_SEND;
      lone.queue_sel = 2'd2;
      lone.data_word = $urandom;
      lone.last_word = 1'b0;
      offer(lone);
      send_message(1, 1, 16'h8000, 1'b0, '0);
      send_message(2, 3, 9, 1'b0, '0);
      receive(2);
      settle();

      // Two-slot ring: one commit, then ring full, then read it back.
      write_register(smm_pkg::CSR_SLOT_COUNT, 9'd2);
      send_message(0, 1, 1, 1'b0, '0);
      send_message(0, 1, 2, 1'b0, '0);
      receive(0);
      settle();

      // No slots in use: commits and non-empty receives report bad index.
      write_register(smm_pkg::CSR_SLOT_COUNT, 9'd0);
      send_message(1, 1, 4, 1'b0, '0);
      receive(3);
      settle();

      // Overwrite on a two-slot ring: the second commit catches the reader.
      write_register(smm_pkg::CSR_SLOT_COUNT, 9'd2);
      write_register(smm_pkg::CSR_OVERWRITE_MODE, 9'd1);
      send_message(0, 1, 3, 1'b0, '0);
      send_message(0, 1, 4, 1'b0, '0);
      receive(0);
      send_message(0, 1, 2, 1'b0, '0);
      receive(0);
      settle();

      // Sender idles lightly, receiver heavily.
      configure(9'd4, 9'd64, 9'd0, 9'd256);
      random_traffic(10);
      settle();

      // Roles swapped; widest lengths, and one message longer than a slot.
      tx_idle_pct = 79;
      rx_idle_pct = 22;
      configure(9'd2, 9'd511, 9'd1, 9'd511);
      send_message(2, SW, 300, 1'b0, '0);
      if (mirror.recv_is_safe(2))
         receive(2);
      random_traffic(6);
      settle();

      // No idling from here on. One-slot ring with overwrite and a small read
      // limit, while the receiver stalls long enough to back up the input.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      configure(9'd1, 9'd256, 9'd1, 9'd16);
      hold_request = 1'b1;
      random_traffic(12);
      settle();

      // Slot count above the ring size, smallest length limits.
      configure(9'd31, 9'd1, 9'd0, 9'd1);
      random_traffic(6);
      settle();

      // One-slot ring without overwrite: a commit into an empty ring reports full.
      configure(9'd1, 9'd256, 9'd0, 9'd256);
      random_traffic(4);
      settle();

      write_register(smm_pkg::CSR_SLOT_COUNT, 9'd0);
      random_traffic(4);
      settle();

      if (mirror.awaited_results.size() != 0) begin
         $display("%0t: %0d responses expected but never seen", $time,
                  mirror.awaited_results.size());
         mirror.mismatches += mirror.awaited_results.size();
      end
      if (mirror.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
